// File: rtl/core/iqdc_pkg.sv
package iqdc_pkg;

   // default sizing
   localparam int MAX_BLOCK_DEF   = 128;
   localparam int SAMPLE_BITS_DEF = 12;

   // configuration port
   localparam int BLK_LEN_W  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [BLK_LEN_W-1:0] BLK_LEN_RST = 8'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLOCK_LENGTH,
      REG_AM_ENABLE
   } csr_idx_type;

   // audio code
   localparam int AUDIO_W = 12;
   localparam logic [AUDIO_W-1:0] MID_CODE = 12'd2048;
   localparam logic [AUDIO_W-1:0] MAX_CODE = 12'd4095;

   // envelope Q format
   localparam int ENV_FRAC = 8;

   // block sequencer
   typedef enum logic [2:0] {
      ST_FILL,
      ST_DIV_GO,
      ST_DIV,
      ST_RD_EVEN,
      ST_RD_ODD,
      ST_CENTER,
      ST_MAG,
      ST_EMIT
   } seq_state_type;

   // envelope unit control
   typedef struct packed {
      logic clear;
      logic mag_en;
      logic update;
   } env_ctrl_type;

endpackage

// File: rtl/core/iqdc_store.sv
module iqdc_store #(
   parameter int DEPTH  = iqdc_pkg::MAX_BLOCK_DEF,
   parameter int DATA_W = 2 * iqdc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/core/iqdc_div.sv
module iqdc_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] dq_ff, dq_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one restoring step per cycle, quotient bits shift into dq
   always_comb begin
      trial   = {rem_ff, dq_ff[NUM_W-1]};
      fits    = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
         dq_in  = {dq_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == LAST_STEP);
   assign quotient = dq_ff;

endmodule

// File: rtl/core/iqdc_env.sv
module iqdc_env #(
   parameter int SAMPLE_BITS = iqdc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  iqdc_pkg::env_ctrl_type            ctrl,
   input  logic                              am_en,
   input  logic signed [SAMPLE_BITS:0]       i_centered,
   input  logic signed [SAMPLE_BITS:0]       q_centered,
   output logic [iqdc_pkg::AUDIO_W-1:0]      audio_code
);

   localparam int MAG_W = SAMPLE_BITS + 1;
   localparam int ENV_W = MAG_W + iqdc_pkg::ENV_FRAC;
   localparam int AC_W  = ((MAG_W > iqdc_pkg::AUDIO_W) ? MAG_W : iqdc_pkg::AUDIO_W) + 2;

   logic [SAMPLE_BITS-1:0]   abs_i, abs_q, mx, mn;
   logic [SAMPLE_BITS+1:0]   three_mn;
   logic [MAG_W-1:0]         mag_in, mag_ff;
   logic [ENV_W-1:0]         env_ff, env_in, env_new;
   logic signed [ENV_W:0]    diff, step, env_sum;
   logic signed [AC_W-1:0]   aud_s;

   // alpha-max-beta-min magnitude of the centered pair
   always_comb begin
      abs_i    = i_centered[SAMPLE_BITS] ? SAMPLE_BITS'(-i_centered)
                                         : i_centered[SAMPLE_BITS-1:0];
      abs_q    = q_centered[SAMPLE_BITS] ? SAMPLE_BITS'(-q_centered)
                                         : q_centered[SAMPLE_BITS-1:0];
      mx       = (abs_i > abs_q) ? abs_i : abs_q;
      mn       = (abs_i > abs_q) ? abs_q : abs_i;
      three_mn = {1'b0, mn, 1'b0} + {2'b00, mn};
      mag_in   = {1'b0, mx} + MAG_W'(three_mn >> 3);
   end

   // envelope mean step: env += floor(((mag << 8) - env) / 256)
   always_comb begin
      diff    = $signed({1'b0, mag_ff, {iqdc_pkg::ENV_FRAC{1'b0}}}) - $signed({1'b0, env_ff});
      step    = diff >>> iqdc_pkg::ENV_FRAC;
      env_sum = $signed({1'b0, env_ff}) + step;
      env_new = env_sum[ENV_W-1:0];
      env_in  = env_ff;
      if (ctrl.clear) begin
         env_in = '0;
      end else if (ctrl.update && am_en) begin
         env_in = env_new;
      end
   end

   // audio code around mid scale, clamped
   always_comb begin
      aud_s = $signed(AC_W'(iqdc_pkg::MID_CODE)) + $signed(AC_W'(mag_ff))
            - $signed(AC_W'(env_new[ENV_W-1:iqdc_pkg::ENV_FRAC]));
      if (!am_en) begin
         audio_code = iqdc_pkg::MID_CODE;
      end else if (aud_s < 0) begin
         audio_code = '0;
      end else if (aud_s > $signed(AC_W'(iqdc_pkg::MAX_CODE))) begin
         audio_code = iqdc_pkg::MAX_CODE;
      end else begin
         audio_code = aud_s[iqdc_pkg::AUDIO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= '0;
      end else begin
         env_ff <= env_in;
      end
      if (ctrl.mag_en) begin
         mag_ff <= mag_in;
      end
   end

endmodule

// File: rtl/core/iq_block_dc_decimate_am_demod_unit.sv
// Block DC removal, decimation by two and AM envelope detection for raw I/Q
// samples. While req_stall is low, samples load one item per cycle into the
// sample store and the I and Q sums run. The item that fills the block
// (block_length, 0 taken as 1 and values above MAX_BLOCK as MAX_BLOCK) closes
// it: req_stall rises and the two means are found by two restoring dividers,
// one quotient bit a cycle. Results then leave one per sample pair, each
// through two reads on the single read port of the sample store, center,
// magnitude and emit; emit waits while a held result sees rsp_stall. No new
// item is taken until the last result of the block is emitted. An odd last
// sample counts in the mean only; a block of one gives no result. Writing
// am_enable from 0 to 1 clears the envelope mean.
module iq_block_dc_decimate_am_demod_unit #(
   parameter int MAX_BLOCK   = iqdc_pkg::MAX_BLOCK_DEF,
   parameter int SAMPLE_BITS = iqdc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [iqdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [iqdc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // sample items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_i_sample,
   input  logic [SAMPLE_BITS-1:0]               req_q_sample,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS:0]          rsp_i_centered,
   output logic signed [SAMPLE_BITS:0]          rsp_q_centered,
   output logic [iqdc_pkg::AUDIO_W-1:0]         rsp_audio_code,
   output logic [SAMPLE_BITS-1:0]               rsp_i_block_mean,
   output logic [SAMPLE_BITS-1:0]               rsp_q_block_mean,
   output logic                                 rsp_block_last
);

   localparam int ADDR_W = $clog2(MAX_BLOCK);
   localparam int FILL_W = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W  = SAMPLE_BITS + FILL_W;
   localparam int CMP_W  = (FILL_W > iqdc_pkg::BLK_LEN_W) ? FILL_W : iqdc_pkg::BLK_LEN_W;
   localparam int DATA_W = 2 * SAMPLE_BITS;
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_BLOCK);

   iqdc_pkg::seq_state_type state_ff, state_in;

   logic [iqdc_pkg::BLK_LEN_W-1:0] blk_len_ff;
   logic                           am_en_ff;
   logic [FILL_W-1:0]              fill_ff, fill_in, pair_ff, pairs, pair_nxt;
   logic [SUM_W-1:0]               isum_ff, qsum_ff;
   logic [ADDR_W-1:0]              addr_ff, rd_addr;
   logic [DATA_W-1:0]              rd_data, even_ff;
   logic signed [SAMPLE_BITS:0]    ci_ff, cq_ff;
   logic [SAMPLE_BITS:0]           avg_i, avg_q;
   logic [CMP_W-1:0]               blk_ext, eff_len;
   logic                           req_fire, store_en, closes, last_pair;
   logic                           div_start, div_done, emit_go, blk_end, env_clear;
   logic [SUM_W-1:0]               mean_i_q, mean_q_q;
   logic [iqdc_pkg::AUDIO_W-1:0]   audio;
   iqdc_pkg::env_ctrl_type         env_ctrl;

   // effective length and block close test
   always_comb begin
      blk_ext = CMP_W'(blk_len_ff);
      if (blk_len_ff == '0) begin
         eff_len = CMP_W'(1);
      end else if (blk_ext > CMP_W'(MAX_BLOCK)) begin
         eff_len = CMP_W'(MAX_BLOCK);
      end else begin
         eff_len = blk_ext;
      end
      req_fire  = req_valid && !req_stall;
      store_en  = req_fire && (fill_ff < FILL_MAX);
      fill_in   = store_en ? fill_ff + FILL_W'(1) : fill_ff;
      closes    = (CMP_W'(fill_in) >= eff_len);
      pairs     = fill_ff >> 1;
      pair_nxt  = pair_ff + FILL_W'(1);
      last_pair = (pair_nxt == pairs);
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iqdc_pkg::ST_FILL: begin
            if (req_fire && closes) state_in = iqdc_pkg::ST_DIV_GO;
         end
         iqdc_pkg::ST_DIV_GO: state_in = iqdc_pkg::ST_DIV;
         iqdc_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (pairs == '0) ? iqdc_pkg::ST_FILL : iqdc_pkg::ST_RD_EVEN;
            end
         end
         iqdc_pkg::ST_RD_EVEN: state_in = iqdc_pkg::ST_RD_ODD;
         iqdc_pkg::ST_RD_ODD:  state_in = iqdc_pkg::ST_CENTER;
         iqdc_pkg::ST_CENTER:  state_in = iqdc_pkg::ST_MAG;
         iqdc_pkg::ST_MAG:     state_in = iqdc_pkg::ST_EMIT;
         iqdc_pkg::ST_EMIT: begin
            if (!rsp_valid || !rsp_stall) begin
               state_in = last_pair ? iqdc_pkg::ST_FILL : iqdc_pkg::ST_RD_EVEN;
            end
         end
         default: state_in = iqdc_pkg::ST_FILL;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != iqdc_pkg::ST_FILL);
      div_start = (state_ff == iqdc_pkg::ST_DIV_GO);
      emit_go   = (state_ff == iqdc_pkg::ST_EMIT) && (!rsp_valid || !rsp_stall);
      blk_end   = ((state_ff == iqdc_pkg::ST_DIV) && div_done && (pairs == '0))
                || (emit_go && last_pair);
      rd_addr   = (state_ff == iqdc_pkg::ST_RD_ODD) ? addr_ff + ADDR_W'(1) : addr_ff;
   end

   // clear the envelope when AM is switched on
   assign env_clear = csr_wr_en && (csr_index == iqdc_pkg::REG_AM_ENABLE)
                    && csr_wdata[0] && !am_en_ff;

   assign env_ctrl = '{clear:  env_clear,
                       mag_en: (state_ff == iqdc_pkg::ST_MAG),
                       update: emit_go};

   // pair average; the block mean is subtracted in ST_CENTER
   always_comb begin
      avg_i = ({1'b0, even_ff[DATA_W-1:SAMPLE_BITS]} + {1'b0, rd_data[DATA_W-1:SAMPLE_BITS]}) >> 1;
      avg_q = ({1'b0, even_ff[SAMPLE_BITS-1:0]} + {1'b0, rd_data[SAMPLE_BITS-1:0]}) >> 1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= iqdc_pkg::ST_FILL;
         blk_len_ff <= iqdc_pkg::BLK_LEN_RST;
         am_en_ff   <= 1'b0;
         fill_ff    <= '0;
         isum_ff    <= '0;
         qsum_ff    <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               iqdc_pkg::REG_BLOCK_LENGTH: blk_len_ff <= csr_wdata;
               iqdc_pkg::REG_AM_ENABLE:    am_en_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         // accumulate, then clear when the block is done
         if (blk_end) begin
            fill_ff <= '0;
            isum_ff <= '0;
            qsum_ff <= '0;
         end else if (store_en) begin
            fill_ff <= fill_in;
            isum_ff <= isum_ff + SUM_W'(req_i_sample);
            qsum_ff <= qsum_ff + SUM_W'(req_q_sample);
         end
         // hold a result until taken
         if (emit_go) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (div_start) begin
         pair_ff <= '0;
         addr_ff <= '0;
      end else if (emit_go) begin
         pair_ff <= pair_nxt;
         addr_ff <= addr_ff + ADDR_W'(2);
      end
      if (state_ff == iqdc_pkg::ST_RD_ODD) begin
         even_ff <= rd_data;
      end
      if (state_ff == iqdc_pkg::ST_CENTER) begin
         ci_ff <= $signed(avg_i) - $signed({1'b0, mean_i_q[SAMPLE_BITS-1:0]});
         cq_ff <= $signed(avg_q) - $signed({1'b0, mean_q_q[SAMPLE_BITS-1:0]});
      end
      if (emit_go) begin
         rsp_i_centered   <= ci_ff;
         rsp_q_centered   <= cq_ff;
         rsp_audio_code   <= audio;
         rsp_i_block_mean <= mean_i_q[SAMPLE_BITS-1:0];
         rsp_q_block_mean <= mean_q_q[SAMPLE_BITS-1:0];
         rsp_block_last   <= last_pair;
      end
   end

   iqdc_store #(
      .DEPTH  (MAX_BLOCK),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data ({req_i_sample, req_q_sample}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   iqdc_div #(
      .NUM_W (SUM_W),
      .DEN_W (FILL_W)
   ) u_div_i (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (isum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (mean_i_q)
   );

   iqdc_div #(
      .NUM_W (SUM_W),
      .DEN_W (FILL_W)
   ) u_div_q (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (qsum_ff),
      .divisor  (fill_ff),
      .done     (),
      .quotient (mean_q_q)
   );

   iqdc_env #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_env (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (env_ctrl),
      .am_en      (am_en_ff),
      .i_centered (ci_ff),
      .q_centered (cq_ff),
      .audio_code (audio)
   );

endmodule

// File: rtl/core/iqdc_check.sv
module iqdc_check #(
   parameter int SAMPLE_BITS = iqdc_pkg::SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS:0]   rsp_i_centered,
   input logic signed [SAMPLE_BITS:0]   rsp_q_centered,
   input logic [iqdc_pkg::AUDIO_W-1:0]  rsp_audio_code,
   input logic                          rsp_block_last
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_i_centered) && $stable(rsp_q_centered)
                                 && $stable(rsp_audio_code) && $stable(rsp_block_last))
      else $error("result payload changed while stalled");

   // mid-block results come only while input is held off
   a_mid_block_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_block_last |-> req_stall)
      else $error("input taken during block emission");

   // centered values never reach the most negative code
   a_center_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_i_centered != {1'b1, {SAMPLE_BITS{1'b0}}})
                 && (rsp_q_centered != {1'b1, {SAMPLE_BITS{1'b0}}}))
      else $error("centered value out of range");

endmodule

bind iq_block_dc_decimate_am_demod_unit iqdc_check #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_check (.*);

// File: tb/tb_iq_block_dc_decimate_am_demod_unit.sv
`timescale 1ns / 1ps

module tb_iq_block_dc_decimate_am_demod_unit;

   localparam int SB            = iqdc_pkg::SAMPLE_BITS_DEF;
   localparam int BLK_MAX       = iqdc_pkg::MAX_BLOCK_DEF;
   localparam int AW            = iqdc_pkg::AUDIO_W;
   localparam int FULL_SCALE    = (1 << SB) - 1;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int RANDOM_ITEMS  = 400;
   localparam int REPORT_MAX    = 10;

   typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_SQUARE, PAT_CLUSTER} pattern_type;

   typedef struct packed {
      logic [SB-1:0] i;
      logic [SB-1:0] q;
   } iq_pair_type;

   typedef struct packed {
      logic signed [SB:0] i_c;
      logic signed [SB:0] q_c;
      logic [AW-1:0]      audio;
      logic [SB-1:0]      i_mean;
      logic [SB-1:0]      q_mean;
      logic               blk_end;
   } demod_type;

   // block ports, all inputs known from time zero
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en = 1'b0;
   logic [iqdc_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [iqdc_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [SB-1:0]                       req_i_sample = '0;
   logic [SB-1:0]                       req_q_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [SB:0]                  rsp_i_centered;
   logic signed [SB:0]                  rsp_q_centered;
   logic [AW-1:0]                       rsp_audio_code;
   logic [SB-1:0]                       rsp_i_block_mean;
   logic [SB-1:0]                       rsp_q_block_mean;
   logic                                rsp_block_last;

   // stimulus and expected result queues
   iq_pair_type sample_q[$];
   demod_type   centered_q[$];
   logic        req_taken = 1'b0;

   // predictor state: held samples, sums, envelope and register copies
   logic [SB-1:0] hist_i[BLK_MAX];
   logic [SB-1:0] hist_q[BLK_MAX];
   int sum_i = 0;
   int sum_q = 0;
   int held = 0;
   int env_q8 = 0;
   int cfg_len = BLK_MAX;
   bit cfg_am = 1'b0;

   // idle rates and the receiver hold request
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // run statistics
   int fail_count = 0;
   int items_in = 0;
   int results_seen = 0;
   int blocks_closed = 0;
   int am_results = 0;
   int clamp_hi = 0;
   int clamp_lo = 0;
   int quiet_cycles = 0;

   iq_block_dc_decimate_am_demod_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_i_sample     (req_i_sample),
      .req_q_sample     (req_q_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_i_centered   (rsp_i_centered),
      .rsp_q_centered   (rsp_q_centered),
      .rsp_audio_code   (rsp_audio_code),
      .rsp_i_block_mean (rsp_i_block_mean),
      .rsp_q_block_mean (rsp_q_block_mean),
      .rsp_block_last   (rsp_block_last)
   );

   always #5 clock = ~clock;

   function automatic int eff_len(int v);
      if (v == 0) return 1;
      if (v > BLK_MAX) return BLK_MAX;
      return v;
   endfunction

   // hold one sample; on a full block work out means and one result per pair
   task automatic take_sample(input logic [SB-1:0] xi, input logic [SB-1:0] xq);
      int n, pairs, mi, mq, ai, aq, ci, cq, ui, uq, mx, mn, mag, audio;
      demod_type r;
      if (held < BLK_MAX) begin
         hist_i[held] = xi;
         hist_q[held] = xq;
         sum_i += xi;
         sum_q += xq;
         held++;
      end
      if (held < eff_len(cfg_len)) return;
      n = held;
      pairs = n >> 1;
      mi = sum_i / n;
      mq = sum_q / n;
      for (int j = 0; j < pairs; j++) begin
         ai = (int'(hist_i[2*j]) + int'(hist_i[2*j+1])) >>> 1;
         aq = (int'(hist_q[2*j]) + int'(hist_q[2*j+1])) >>> 1;
         ci = ai - mi;
         cq = aq - mq;
         audio = int'(iqdc_pkg::MID_CODE);
         if (cfg_am) begin
            ui = (ci < 0) ? -ci : ci;
            uq = (cq < 0) ? -cq : cq;
            mx = (ui > uq) ? ui : uq;
            mn = (ui > uq) ? uq : ui;
            mag = mx + ((3 * mn) >>> 3);
            // Q8 envelope, floor step for either sign
            env_q8 += (mag * 256 - env_q8) >>> iqdc_pkg::ENV_FRAC;
            audio = int'(iqdc_pkg::MID_CODE) + mag - (env_q8 >>> iqdc_pkg::ENV_FRAC);
            am_results++;
            if (audio < 0) begin
               audio = 0;
               clamp_lo++;
            end else if (audio > int'(iqdc_pkg::MAX_CODE)) begin
               audio = int'(iqdc_pkg::MAX_CODE);
               clamp_hi++;
            end
         end
         r.i_c = (SB+1)'(ci);
         r.q_c = (SB+1)'(cq);
         r.audio = AW'(audio);
         r.i_mean = SB'(mi);
         r.q_mean = SB'(mq);
         r.blk_end = (j + 1 == pairs);
         centered_q.push_back(r);
      end
      held = 0;
      sum_i = 0;
      sum_q = 0;
      blocks_closed++;
   endtask

   // sample both handshakes, predict on accepted items, check accepted results
   always @(posedge clock) begin
      demod_type got, want;
      logic in_fire, out_fire;
      in_fire = !reset && req_valid && !req_stall;
      out_fire = !reset && rsp_valid && !rsp_stall;
      req_taken <= in_fire;
      if (in_fire) begin
         take_sample(req_i_sample, req_q_sample);
         items_in++;
      end
      if (out_fire) begin
         got.i_c = rsp_i_centered;
         got.q_c = rsp_q_centered;
         got.audio = rsp_audio_code;
         got.i_mean = rsp_i_block_mean;
         got.q_mean = rsp_q_block_mean;
         got.blk_end = rsp_block_last;
         if (centered_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("ERROR: unexpected result i_c %0d q_c %0d audio %0d",
                        got.i_c, got.q_c, got.audio);
         end else begin
            want = centered_q.pop_front();
            if (got.i_c !== want.i_c || got.q_c !== want.q_c ||
                got.audio !== want.audio || got.i_mean !== want.i_mean ||
                got.q_mean !== want.q_mean || got.blk_end !== want.blk_end) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display({"ERROR: result %0d exp/got i_c %0d/%0d q_c %0d/%0d",
                            " audio %0d/%0d mean %0d,%0d/%0d,%0d last %0b/%0b"},
                           results_seen, want.i_c, got.i_c, want.q_c, got.q_c,
                           want.audio, got.audio, want.i_mean, want.q_mean,
                           got.i_mean, got.q_mean, want.blk_end, got.blk_end);
            end
            results_seen++;
         end
      end
      if (in_fire || out_fire || csr_wr_en) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // offer the next item once the current one is taken, with random gaps
   always @(negedge clock) begin
      iq_pair_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = sample_q.pop_front();
            req_valid <= 1'b1;
            req_i_sample <= nxt.i;
            req_q_sample <= nxt.q;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall results at random, or for a long hold when one is requested
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // end the run when nothing moves for too long
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   task automatic write_reg(input iqdc_pkg::csr_idx_type idx, input int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= iqdc_pkg::CSR_DATA_W'(val);
      if (idx == iqdc_pkg::REG_BLOCK_LENGTH) begin
         cfg_len = val & 8'hFF;
      end else begin
         if (val[0] && !cfg_am) env_q8 = 0;
         cfg_am = val[0];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_pair(input int vi, input int vq);
      iq_pair_type p;
      p.i = SB'(vi);
      p.q = SB'(vq);
      sample_q.push_back(p);
   endtask

   task automatic push_run(input int count, input pattern_type pat);
      int ci, cq, vi, vq;
      ci = $urandom_range(FULL_SCALE - 64, 64);
      cq = $urandom_range(FULL_SCALE - 64, 64);
      for (int k = 0; k < count; k++) begin
         case (pat)
            PAT_EXTREME: begin
               vi = $urandom_range(1) ? FULL_SCALE : 0;
               vq = $urandom_range(1) ? FULL_SCALE : 0;
            end
            PAT_SQUARE: begin
               vi = ((k >> 1) & 1) ? FULL_SCALE - $urandom_range(15) : $urandom_range(15);
               vq = ((k >> 2) & 1) ? FULL_SCALE - $urandom_range(15) : $urandom_range(15);
            end
            PAT_CLUSTER: begin
               vi = ci + $urandom_range(64) - 32;
               vq = cq + $urandom_range(64) - 32;
            end
            default: begin
               vi = $urandom_range(FULL_SCALE);
               vq = $urandom_range(FULL_SCALE);
            end
         endcase
         push_pair(vi, vq);
      end
   endtask

   // wait until every item is in and every result is out, then let the block idle
   task automatic settle();
      while (sample_q.size() != 0 || req_valid || centered_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int rand_sent, r, len, eff, n;
      bit recv_turn, calm;
      rand_sent = 0;
      recv_turn = 1'b0;
      calm = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 83;

      // AM off: audio stays at mid code
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 2);
      write_reg(iqdc_pkg::REG_AM_ENABLE, 0);
      push_pair(0, FULL_SCALE);
      push_pair(FULL_SCALE, 0);
      settle();
      // AM turned on clears the envelope; full swing drives audio to its top clamp
      write_reg(iqdc_pkg::REG_AM_ENABLE, 1);
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 4);
      push_pair(0, 0);
      push_pair(0, 0);
      push_pair(FULL_SCALE, FULL_SCALE);
      push_pair(FULL_SCALE, FULL_SCALE);
      settle();
      // AM rewritten while on keeps the envelope; odd count drops the last from pairs
      write_reg(iqdc_pkg::REG_AM_ENABLE, 1);
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 3);
      push_pair(FULL_SCALE, 0);
      push_pair(FULL_SCALE, 0);
      push_pair(0, FULL_SCALE);
      settle();
      // block of one closes with no result
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 1);
      push_pair(1234, 2345);
      settle();
      // length zero behaves as one
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 0);
      push_pair(FULL_SCALE, FULL_SCALE);
      push_pair(0, 0);
      settle();
      // length above the store size, then lowered mid-block with AM off
      write_reg(iqdc_pkg::REG_AM_ENABLE, 0);
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 255);
      push_run(5, PAT_NOISE);
      settle();
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 2);
      push_pair(2047, 2048);
      settle();

      // one full-size block of loud carrier with AM on
      write_reg(iqdc_pkg::REG_BLOCK_LENGTH, BLK_MAX);
      write_reg(iqdc_pkg::REG_AM_ENABLE, 1);
      push_run(BLK_MAX, PAT_SQUARE);
      rand_sent = BLK_MAX;

      while (rand_sent < RANDOM_ITEMS) begin
         if (!recv_turn && rand_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 83;
            recv_idle_pct = 14;
            recv_turn = 1'b1;
         end
         if (!calm && rand_sent >= 2 * RANDOM_ITEMS / 3) begin
            // no idling; hold results off long enough to back the input up
            send_idle_pct = 0;
            recv_idle_pct = 0;
            calm = 1'b1;
            settle();
            write_reg(iqdc_pkg::REG_BLOCK_LENGTH, 16);
            hold_token++;
            push_run(48, PAT_NOISE);
            rand_sent += 48;
         end
         settle();
         r = $urandom_range(99);
         if (r < 3) len = BLK_MAX;
         else if (r < 6) len = $urandom_range(255, BLK_MAX + 1);
         else if (r < 12) len = $urandom_range(1);
         else len = $urandom_range(16, 2);
         write_reg(iqdc_pkg::REG_BLOCK_LENGTH, len);
         if ($urandom_range(9) < 3)
            write_reg(iqdc_pkg::REG_AM_ENABLE, $urandom_range(9) < 7);
         eff = eff_len(len);
         if (eff == BLK_MAX) n = eff;
         else if (eff == 1) n = $urandom_range(6, 2);
         else n = eff * $urandom_range(3, 1);
         // leave a partial block behind now and then
         if (eff > 1 && $urandom_range(3) == 0) n += $urandom_range(eff - 1, 1);
         push_run(n, pattern_type'($urandom_range(3)));
         rand_sent += n;
      end
      settle();
      repeat (60) @(negedge clock);

      if (centered_q.size() != 0) begin
         $display("ERROR: %0d results never arrived", centered_q.size());
         fail_count++;
      end
      $display("Run covered %0d sample items, %0d results over %0d closed blocks,",
               items_in, results_seen, blocks_closed);
      $display("%0d results with AM on; audio clamped high %0d and low %0d times.",
               am_results, clamp_hi, clamp_lo);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
